@@ rtl/frame_store_lru_tracker_macros.svh @@
// ----------------------------------------------------------------------------
// Frame store LRU tracker assertion macros
// Concurrent assertion wrappers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FRAME_STORE_LRU_TRACKER_MACROS_SVH
`define FRAME_STORE_LRU_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define FSLT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("fslt assertion failed");
`define FSLT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fslt assertion failed");
`else
`define FSLT_ASSERT(lbl, clk, rstn, prop)
`define FSLT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/fslt_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame store LRU tracker package
// Sizes, operation codes and shared types of the frame store LRU tracker.
// ----------------------------------------------------------------------------
package fslt_pkg;

    localparam int SLOTS     = 48;
    localparam int PAGE_SIZE = 3;
    localparam int FRAMES    = (SLOTS + PAGE_SIZE - 1) / PAGE_SIZE;
    localparam int SLOT_W    = 6;
    localparam int FRAME_W   = 4;
    localparam int BYTE_W    = 8;
    localparam int GRP       = 8;
    localparam int GRP_W     = $clog2(GRP);
    localparam int NGRP      = (SLOTS + GRP - 1) / GRP;
    localparam int NGRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;

    localparam logic [2:0] FN_INSERT     = 3'd0;
    localparam logic [2:0] FN_READ_TOUCH = 3'd1;
    localparam logic [2:0] FN_READ_PLAIN = 3'd2;
    localparam logic [2:0] FN_REMOVE     = 3'd3;
    localparam logic [2:0] FN_EVICT      = 3'd4;

    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_FRONT = 2'd1;
    localparam logic [1:0] CELL_DROP  = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [FRAME_W-1:0] frame;
    } cell_ctrl_t;

    function automatic logic [FRAME_W-1:0] frame_of(input logic [SLOT_W-1:0] s);
        logic [FRAME_W-1:0] r;
        r = '0;
        for (int f = 0; f < FRAMES; f++) begin
            if (s >= SLOT_W'(f * PAGE_SIZE)) begin
                r = FRAME_W'(f);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/fslt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
module fslt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/fslt_cell.sv @@
// ----------------------------------------------------------------------------
// Recency chain cell
// Holds one position of the frame order and shifts from its left neighbor.
// ----------------------------------------------------------------------------
module fslt_cell
    import fslt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cell_ctrl_t         ctrl,
    input  logic               shift_en,
    input  logic [FRAME_W-1:0] left_frame,
    input  logic               left_vld,
    input  logic               right_vld,
    output logic [FRAME_W-1:0] frame,
    output logic               vld,
    output logic               hit,
    output logic [FRAME_W-1:0] frame_nxt,
    output logic               vld_nxt
);

    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic               vld_reg, vld_next;

    always_comb begin
        frame_next = frame_reg;
        vld_next   = vld_reg;
        case (ctrl.op)
            CELL_FRONT: begin
                if (shift_en) begin
                    frame_next = left_frame;
                    vld_next   = left_vld;
                end
            end
            CELL_DROP: begin
                vld_next = vld_reg & right_vld;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign frame     = frame_reg;
    assign vld       = vld_reg;
    assign hit       = vld_reg && (frame_reg == ctrl.frame);
    assign frame_nxt = frame_next;
    assign vld_nxt   = vld_next;

endmodule

@@ rtl/fslt_free_find.sv @@
// ----------------------------------------------------------------------------
// Free slot finder
// Registers a per-group first-free search, then picks the lowest group.
// ----------------------------------------------------------------------------
module fslt_free_find
    import fslt_pkg::*;
(
    input  logic              aclk,
    input  logic              load,
    input  logic [SLOTS-1:0]  used,
    output logic              free_any,
    output logic [SLOT_W-1:0] free_slot
);

    logic [NGRP*GRP-1:0] pad;
    logic [NGRP-1:0]     grp_any_next, grp_any_reg;
    logic [GRP_W-1:0]    grp_idx_next [NGRP];
    logic [GRP_W-1:0]    grp_idx_reg  [NGRP];
    logic [NGRP_W-1:0]   sel;

    always_comb begin
        pad = '1;
        for (int i = 0; i < SLOTS; i++) begin
            pad[i] = used[i];
        end
        for (int g = 0; g < NGRP; g++) begin
            grp_any_next[g] = ~&pad[g*GRP +: GRP];
            grp_idx_next[g] = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                if (!pad[g*GRP + j]) begin
                    grp_idx_next[g] = GRP_W'(j);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            grp_any_reg <= grp_any_next;
            grp_idx_reg <= grp_idx_next;
        end
    end

    always_comb begin
        sel = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                sel = NGRP_W'(g);
            end
        end
    end

    assign free_any  = |grp_any_reg;
    assign free_slot = SLOT_W'({sel, grp_idx_reg[sel]});

endmodule

@@ rtl/frame_store_lru_tracker.sv @@
// ----------------------------------------------------------------------------
// Frame store LRU tracker
// Slot store with a least-recently-used order over frames of slots.
// ----------------------------------------------------------------------------
// Each transfer passes through an idle and an execute state. Accepting it in
// the idle state starts the registered slot RAM read and the per-group
// free-slot search; the execute state then picks the free slot, moves the frame
// through the recency chain of cells in one step and loads the result register.
// A new transfer is taken only after the block returns to idle, so transfers do
// not overlap; a stalled result holds the execute state until the register empties.

`include "frame_store_lru_tracker_macros.svh"

module frame_store_lru_tracker
    import fslt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[2:0], proc_id[10:3], page_number[18:11], slot[24:19], zeros
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[0], slot_index[6:1], proc_id_out[14:7], page_out[22:15],
    // slot_valid[23], lru_frame[27:24], lru_valid[28], zeros
    output logic [31:0] m_tdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic              state_reg, state_next;
    logic [2:0]        func_reg;
    logic [BYTE_W-1:0] pid_reg, pn_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOTS-1:0]  used_reg, used_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;

    logic              s_accept, complete, in_range, s_in_range;
    logic              free_any, ins, ins_ok, valid_out;
    logic [SLOT_W-1:0] free_slot, sidx_out;
    logic [2*BYTE_W-1:0] ram_rdata;
    cell_ctrl_t        ctrl;
    logic [FRAMES-1:0] hit_vec, cell_vld, vld_nxt, shift_en;
    logic [FRAME_W-1:0] cell_frame [FRAMES];
    logic [FRAME_W-1:0] frame_nxt  [FRAMES];
    logic [FRAME_W-1:0] lru_frame;
    logic              lru_valid;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign s_in_range = s_tdata[24:19] < SLOT_W'(SLOTS);
    assign complete   = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign in_range   = slot_reg < SLOT_W'(SLOTS);
    assign ins        = (func_reg == FN_INSERT);
    assign ins_ok     = ins && free_any;

    fslt_free_find u_free (
        .aclk      (aclk),
        .load      (s_accept),
        .used      (used_reg),
        .free_any  (free_any),
        .free_slot (free_slot)
    );

    fslt_ram #(
        .WIDTH (2 * BYTE_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (complete && ins_ok),
        .waddr (free_slot),
        .wdata ({pn_reg, pid_reg}),
        .re    (s_accept && s_in_range),
        .raddr (s_tdata[24:19]),
        .rdata (ram_rdata)
    );

    always_comb begin
        ctrl.frame = ins ? frame_of(free_slot) : frame_of(slot_reg);
        ctrl.op    = CELL_HOLD;
        if (complete) begin
            if (ins_ok || (func_reg == FN_READ_TOUCH && in_range)) begin
                ctrl.op = CELL_FRONT;
            end else if (func_reg == FN_EVICT) begin
                ctrl.op = CELL_DROP;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < FRAMES; k++) begin
            shift_en[k] = !(|hit_vec) || ((hit_vec >> k) != '0);
        end
    end

    for (genvar k = 0; k < FRAMES; k++) begin : g_cell
        logic [FRAME_W-1:0] left_frame;
        logic               left_vld, right_vld;
        if (k == 0) begin : g_head
            assign left_frame = ctrl.frame;
            assign left_vld   = 1'b1;
        end else begin : g_body
            assign left_frame = cell_frame[k-1];
            assign left_vld   = cell_vld[k-1];
        end
        if (k == FRAMES - 1) begin : g_tail
            assign right_vld = 1'b0;
        end else begin : g_inner
            assign right_vld = cell_vld[k+1];
        end
        fslt_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .shift_en   (shift_en[k]),
            .left_frame (left_frame),
            .left_vld   (left_vld),
            .right_vld  (right_vld),
            .frame      (cell_frame[k]),
            .vld        (cell_vld[k]),
            .hit        (hit_vec[k]),
            .frame_nxt  (frame_nxt[k]),
            .vld_nxt    (vld_nxt[k])
        );
    end

    always_comb begin
        lru_frame = '0;
        for (int k = 0; k < FRAMES; k++) begin
            if (vld_nxt[k] && (k == FRAMES - 1 || !vld_nxt[(k + 1) % FRAMES])) begin
                lru_frame = lru_frame | frame_nxt[k];
            end
        end
        lru_valid = vld_nxt[0];
    end

    always_comb begin
        used_next = used_reg;
        if (complete) begin
            if (ins_ok) begin
                used_next[free_slot] = 1'b1;
            end
            if (func_reg == FN_REMOVE && in_range) begin
                used_next[slot_reg] = 1'b0;
            end
        end
    end

    always_comb begin
        sidx_out  = '0;
        valid_out = 1'b0;
        if (ins) begin
            sidx_out  = ins_ok ? free_slot : '0;
            valid_out = ins_ok;
        end else if (func_reg == FN_READ_TOUCH || func_reg == FN_READ_PLAIN ||
                     func_reg == FN_REMOVE) begin
            sidx_out  = slot_reg;
            valid_out = in_range && (func_reg != FN_REMOVE) && used_reg[slot_reg];
        end
        m_tdata_next = '0;
        m_tdata_next[0]     = ins && !free_any;
        m_tdata_next[6:1]   = sidx_out;
        if (valid_out) begin
            m_tdata_next[14:7]  = ins ? pid_reg : ram_rdata[BYTE_W-1:0];
            m_tdata_next[22:15] = ins ? pn_reg  : ram_rdata[2*BYTE_W-1:BYTE_W];
        end
        m_tdata_next[23]    = valid_out;
        m_tdata_next[27:24] = lru_frame;
        m_tdata_next[28]    = lru_valid;
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (complete) begin
                    state_next    = ST_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            func_reg <= s_tdata[2:0];
            pid_reg  <= s_tdata[10:3];
            pn_reg   <= s_tdata[18:11];
            slot_reg <= s_tdata[24:19];
        end
        if (complete) begin
            m_tdata_reg <= m_tdata_next;
        end
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `FSLT_ASSERT(a_order_packed, aclk, aresetn, ((cell_vld + FRAMES'(1)) & cell_vld) == '0)
    `FSLT_ASSERT(a_accept_exec, aclk, aresetn, (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
    `FSLT_ASSERT(a_single_hit, aclk, aresetn, (state_reg == ST_EXEC) |-> $onehot0(hit_vec))
    `FSLT_ASSERT(a_insert_marks, aclk, aresetn, (complete && ins_ok) |=> used_reg[$past(free_slot)])

endmodule
